### rtl/ufc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ufc_pkg;

    typedef enum logic [1:0] {
        ST_PENDING = 2'd0,
        ST_GOOD    = 2'd1,
        ST_BAD     = 2'd2,
        ST_DROP    = 2'd3
    } t_status;

    // reflected crc-8, lsb first
    localparam logic [7:0] CRC_POLY   = 8'h8C;
    // count at which the length byte arrives, also the shortest frame
    localparam logic [7:0] LEN_COUNT  = 8'd3;
    localparam logic [7:0] LEN_OFFSET = 8'd2;
    localparam int unsigned BUF_EXTRA = 14;

endpackage

`default_nettype wire

### rtl/ufc_rx_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ufc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### rtl/ufc_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ufc_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] frame_bytes;

    modport source (output valid, output status, output frame_bytes, input ready);
    modport sink (input valid, input status, input frame_bytes, output ready);
endinterface

`default_nettype wire

### rtl/uart_frame_crc8_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// output: a word's result is registered and shows on o_res in the cycle after accept
// throughput: one word per cycle while o_res does not stall; the crc step and the end compare are in the same cycle
// the result register frees i_rx while a result waits, unless o_res stalls with it full
// reset: synchronous active low, clears count, length target, crc and result valid
module uart_frame_crc8_checker #(
    parameter int unsigned PAGE_BYTES = 128
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ufc_rx_if.sink    i_rx,
    ufc_res_if.source o_res
);

    localparam logic [7:0] CAPACITY = 8'(PAGE_BYTES + ufc_pkg::BUF_EXTRA);

    logic [7:0] r_count;
    logic [7:0] r_target;
    logic [7:0] r_crc;
    logic       r_out_valid;
    logic [1:0] r_out_status;
    logic [7:0] r_out_bytes;

    logic       accept;
    logic       full;
    logic [7:0] count;
    logic [7:0] len_sum;
    logic [7:0] target;
    logic       at_end;
    logic [7:0] crc_next;
    ufc_pkg::t_status status;

    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign accept     = i_rx.valid && i_rx.ready;
    assign full       = (r_count >= CAPACITY);
    assign count      = r_count + 8'd1;
    assign len_sum    = i_rx.rx_byte + ufc_pkg::LEN_OFFSET;

    // length byte sets the end count, short lengths clamp to the minimum frame
    always_comb begin
        if (count == ufc_pkg::LEN_COUNT) begin
            target = (len_sum < ufc_pkg::LEN_COUNT) ? ufc_pkg::LEN_COUNT : len_sum;
        end else begin
            target = r_target;
        end
    end

    assign at_end = (count >= ufc_pkg::LEN_COUNT) && (count == target);

    ufc_crc8 u_crc8 (
        .i_crc  (r_crc),
        .i_byte (i_rx.rx_byte),
        .o_crc  (crc_next)
    );

    always_comb begin
        if (full) begin
            status = ufc_pkg::ST_DROP;
        end else if (at_end) begin
            status = (i_rx.rx_byte == r_crc) ? ufc_pkg::ST_GOOD : ufc_pkg::ST_BAD;
        end else begin
            status = ufc_pkg::ST_PENDING;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_target <= '0;
            r_crc    <= '0;
        end else if (accept && !full) begin
            if (at_end) begin
                r_count  <= '0;
                r_target <= '0;
                r_crc    <= '0;
            end else begin
                r_count  <= count;
                r_target <= target;
                if (count >= ufc_pkg::LEN_COUNT) begin
                    r_crc <= crc_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_status <= status;
            r_out_bytes  <= full ? r_count : count;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.frame_bytes = r_out_bytes;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAPACITY)
        else $error("byte count past buffer capacity");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted word produced no result");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !full && at_end) |=> (r_count == '0 && r_crc == '0 && r_target == '0))
        else $error("frame end did not clear frame state");

    a_drop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && full) |=> ($stable(r_count) && $stable(r_crc) && $stable(r_target)))
        else $error("dropped word changed frame state");
`endif

endmodule

`default_nettype wire

### rtl/ufc_crc8.sv
`timescale 1ns / 1ps
`default_nettype none

module ufc_crc8 (
    input  wire logic [7:0] i_crc,
    input  wire logic [7:0] i_byte,
    output logic      [7:0] o_crc
);

    always_comb begin
        logic [7:0] crc;
        logic [7:0] b;
        crc = i_crc;
        b   = i_byte;
        for (int k = 0; k < 8; k++) begin
            if ((crc[0] ^ b[0]) == 1'b1) begin
                crc = (crc >> 1) ^ ufc_pkg::CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
            b = b >> 1;
        end
        o_crc = crc;
    end

endmodule

`default_nettype wire

### tb/uart_frame_crc8_checker_tb.sv
`timescale 1ns / 1ps

module uart_frame_crc8_checker_tb;

    localparam int unsigned PAGE_BYTES   = 128;
    localparam int unsigned RX_CAPACITY  = PAGE_BYTES + ufc_pkg::BUF_EXTRA;
    localparam int unsigned RANDOM_BYTES = 1200;
    localparam int unsigned MAX_REPORTS  = 10;

    typedef struct packed {
        ufc_pkg::t_status status;
        logic [7:0]       frame_bytes;
    } t_frame_result;

    logic i_clk;
    logic i_rst_n;

    ufc_rx_if  rx_bus ();
    ufc_res_if res_bus ();

    uart_frame_crc8_checker #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rx   (rx_bus.sink),
        .o_res  (res_bus.source)
    );

    // predictor state
    logic [7:0] model_count;
    logic [7:0] model_target;
    logic [7:0] model_crc;

    t_frame_result pending_results[$];

    int unsigned bytes_sent;
    int unsigned results_seen;
    int unsigned frames_good;
    int unsigned frames_bad;
    int unsigned bytes_dropped;
    int unsigned mismatches;
    bit          no_idle;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(4_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            c = (c[0] ^ b[k]) ? ((c >> 1) ^ ufc_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic t_frame_result predict_byte(input logic [7:0] b);
        t_frame_result r;
        logic [7:0]    t;
        r.status = ufc_pkg::ST_PENDING;
        if (model_count >= RX_CAPACITY) begin
            r.status      = ufc_pkg::ST_DROP;
            r.frame_bytes = model_count;
            return r;
        end
        model_count   = model_count + 8'd1;
        r.frame_bytes = model_count;
        if (model_count == ufc_pkg::LEN_COUNT) begin
            t            = b + ufc_pkg::LEN_OFFSET;
            model_target = (t < ufc_pkg::LEN_COUNT) ? ufc_pkg::LEN_COUNT : t;
        end
        if (model_count >= ufc_pkg::LEN_COUNT) begin
            if (model_count == model_target) begin
                r.status     = (b == model_crc) ? ufc_pkg::ST_GOOD : ufc_pkg::ST_BAD;
                model_count  = 8'd0;
                model_target = 8'd0;
                model_crc    = 8'd0;
            end else begin
                model_crc = crc8_step(model_crc, b);
            end
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // one word per call, with a random gap before it unless no_idle is set
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            rx_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_bus.valid   <= 1'b1;
        rx_bus.rx_byte <= b;
        do @(posedge i_clk); while (!rx_bus.ready);
        pending_results.push_back(predict_byte(b));
        bytes_sent++;
    endtask

    // sender holds off until every result is back
    task automatic wait_for_results();
        rx_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // header, length, payload and crc; lengths 0, 1, 254 and 255 end on the length byte
    task automatic send_frame(input logic [7:0] hdr0, input logic [7:0] hdr1,
                              input logic [7:0] len, input bit corrupt);
        int unsigned span;
        logic [7:0]  crc;
        logic [7:0]  d;
        send_byte(hdr0);
        send_byte(hdr1);
        send_byte(len);
        span = (int'(len) + 2) % 256;
        if (span < 3) span = 3;
        if (span > 3) begin
            crc = crc8_step(8'h00, len);
            for (int i = 4; i < span; i++) begin
                d = 8'($urandom_range(0, 255));
                send_byte(d);
                crc = crc8_step(crc, d);
            end
            send_byte(corrupt ? (crc ^ 8'($urandom_range(1, 255))) : crc);
        end
    endtask

    task automatic test_short_lengths();
        send_frame(8'h00, 8'h00, 8'h00, 1'b0);
        send_frame(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_frame(8'h55, 8'hAA, 8'h01, 1'b0);
        send_frame(8'hAA, 8'h55, 8'hFE, 1'b0);
    endtask

    task automatic test_small_frames();
        send_frame(8'h12, 8'h34, 8'h02, 1'b0);
        send_frame(8'h80, 8'h01, 8'h03, 1'b1);
        send_frame(8'h7F, 8'hFE, 8'h02, 1'b1);
    endtask

    task automatic test_full_buffer_frame();
        // length 140 ends exactly at capacity
        send_frame(8'h3C, 8'hC3, 8'(RX_CAPACITY - 2), 1'b0);
        wait_for_results();
    endtask

    task automatic test_random_frames();
        int unsigned stop_at;
        int unsigned frame_no;
        int unsigned pick;
        logic [7:0]  len;
        stop_at  = bytes_sent + RANDOM_BYTES;
        frame_no = 0;
        while (bytes_sent < stop_at) begin
            no_idle = ($urandom_range(0, 9) == 0);
            pick    = $urandom_range(0, 99);
            if (pick < 60) begin
                len = 8'($urandom_range(2, 20));
            end else if (pick < 75) begin
                case ($urandom_range(0, 3))
                    0:       len = 8'h00;
                    1:       len = 8'h01;
                    2:       len = 8'hFE;
                    default: len = 8'hFF;
                endcase
            end else if (pick < 95) begin
                len = 8'($urandom_range(21, 60));
            end else begin
                len = 8'($urandom_range(61, RX_CAPACITY - 2));
            end
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
                       $urandom_range(0, 3) == 0);
            frame_no++;
            if (frame_no == 50) wait_for_results();
        end
        no_idle = 1'b0;
        wait_for_results();
    endtask

    // a length past capacity never ends, so this runs last
    task automatic test_capacity_lock();
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'(RX_CAPACITY - 1));
        for (int i = 0; i < RX_CAPACITY + 8; i++) begin
            send_byte(8'($urandom_range(0, 255)));
        end
        wait_for_results();
    endtask

    // sink side: random stall before each result unless no_idle is set
    initial begin
        int unsigned stall;
        res_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!res_bus.valid);
        end
    end

    always @(posedge i_clk) begin
        t_frame_result want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            results_seen++;
            case (ufc_pkg::t_status'(res_bus.status))
                ufc_pkg::ST_GOOD: frames_good++;
                ufc_pkg::ST_BAD:  frames_bad++;
                ufc_pkg::ST_DROP: bytes_dropped++;
                default: ;
            endcase
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("unexpected result status=%0d frame_bytes=%0d",
                                        res_bus.status, res_bus.frame_bytes));
            end else begin
                want = pending_results.pop_front();
                if (res_bus.status !== want.status) begin
                    note_mismatch($sformatf("status expected %s got %0d (frame_bytes %0d)",
                                            want.status.name(), res_bus.status,
                                            want.frame_bytes));
                end
                if (res_bus.frame_bytes !== want.frame_bytes) begin
                    note_mismatch($sformatf("frame_bytes expected %0d got %0d",
                                            want.frame_bytes, res_bus.frame_bytes));
                end
            end
        end
    end

    initial begin
        model_count   = 8'd0;
        model_target  = 8'd0;
        model_crc     = 8'd0;
        bytes_sent    = 0;
        results_seen  = 0;
        frames_good   = 0;
        frames_bad    = 0;
        bytes_dropped = 0;
        mismatches    = 0;
        no_idle       = 1'b0;
        i_rst_n        <= 1'b0;
        rx_bus.valid   <= 1'b0;
        rx_bus.rx_byte <= 8'h00;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_short_lengths();
        test_small_frames();
        wait_for_results();
        test_full_buffer_frame();
        test_random_frames();
        test_capacity_lock();

        repeat (20) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end
        $display("sent %0d bytes, checked %0d results", bytes_sent, results_seen);
        $display("frames good %0d, crc errors %0d, dropped on full buffer %0d, mismatches %0d",
                 frames_good, frames_bad, bytes_dropped, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### sim.f
rtl/ufc_pkg.sv
rtl/ufc_rx_if.sv
rtl/ufc_res_if.sv
rtl/ufc_crc8.sv
rtl/uart_frame_crc8_checker.sv
tb/uart_frame_crc8_checker_tb.sv
